[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[src/cvp_pkg.sv]
package cvp_pkg;

	localparam int COORD_BITS_DEF = 16;
	// wide enough for coordinate plus window width without wrap
	localparam int WIDE = 17;

	// register indexes
	localparam logic [2:0] REG_DESK_WIDTH     = 3'd0;
	localparam logic [2:0] REG_DESK_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_VISIBLE_WIDTH  = 3'd2;
	localparam logic [2:0] REG_VISIBLE_HEIGHT = 3'd3;
	localparam logic [2:0] REG_PIXEL_FORMAT   = 3'd4;
	localparam logic [2:0] REG_HEAD_MODE      = 3'd5;
	localparam logic [2:0] REG_CURSOR_HOTSPOT = 3'd6;
	localparam logic [2:0] REG_CRTCS_SWAPPED  = 3'd7;

	// pixel formats
	localparam logic [2:0] FMT_PAL8  = 3'd0;
	localparam logic [2:0] FMT_RGB15 = 3'd1;
	localparam logic [2:0] FMT_RGB16 = 3'd2;
	localparam logic [2:0] FMT_RGB32 = 3'd3;

	// head modes
	localparam logic [1:0] HEAD_SINGLE      = 2'd0;
	localparam logic [1:0] HEAD_DUAL_ON     = 2'd1;
	localparam logic [1:0] HEAD_DUAL_SWITCH = 2'd2;

	// start alignment masks
	localparam logic [4:0] GRAN_DUAL       = 5'h1f;
	localparam logic [4:0] GRAN_DUAL_RGB32 = 5'h0f;
	localparam logic [4:0] GRAN_PAL8       = 5'h07;
	localparam logic [4:0] GRAN_RGB16      = 5'h03;
	localparam logic [4:0] GRAN_RGB32      = 5'h01;

	typedef struct packed {
		logic [13:0] desk_width;
		logic [13:0] desk_height;
		logic [12:0] visible_width;
		logic [12:0] visible_height;
		logic [2:0]  pixel_format;
		logic [1:0]  head_mode;
		logic [11:0] cursor_hotspot;
		logic        crtcs_swapped;
	} cvp_cfg_t;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
	} cvp_in_t;

	typedef struct packed {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic [15:0]        start_x;
		logic [15:0]        start_y;
		logic               start_moved;
	} cvp_out_t;

endpackage

[src/cursor_viewport_pan_top.sv]
// Channel    Direction  Handshake                  Payload
// cursor     in         cursor_valid/cursor_ready  cvp_in_t  (pos_x, pos_y)
// pan        out        pan_valid/pan_ready        cvp_out_t (screen, start, moved)
// cfg        in         cfg_we                     cfg_index, cfg_data
//
// Each transaction passes through the input register and then the result
// register; throughput is one transaction per cycle while pan_ready stays high,
// with the pan update on the two start registers committed on each advance.
// Reset clears the start registers and loads the configuration defaults.
// A stalled result holds in the result register while the input register
// keeps one more transaction; cursor_ready drops only when both are full.
`include "assert_macros.svh"

module cursor_viewport_pan_top #(
	parameter int COORD_BITS = cvp_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cursor_valid,
	output logic              cursor_ready,
	input  cvp_pkg::cvp_in_t  cursor,
	output logic              pan_valid,
	input  logic              pan_ready,
	output cvp_pkg::cvp_out_t pan,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [13:0]       cfg_data
);
	import cvp_pkg::*;

	cvp_cfg_t cfg_q;
	cvp_in_t  item_s1;
	logic     valid_s1;
	cvp_out_t result;
	cvp_out_t pan_q;
	logic     pan_valid_q;
	logic     advance;

	// configuration registers; the user must write them only while idle, not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.desk_width     <= 14'd1024;
			cfg_q.desk_height    <= 14'd768;
			cfg_q.visible_width  <= 13'd1024;
			cfg_q.visible_height <= 13'd768;
			cfg_q.pixel_format   <= FMT_RGB32;
			cfg_q.head_mode      <= HEAD_SINGLE;
			cfg_q.cursor_hotspot <= '0;
			cfg_q.crtcs_swapped  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DESK_WIDTH:     cfg_q.desk_width     <= cfg_data;
				REG_DESK_HEIGHT:    cfg_q.desk_height    <= cfg_data;
				REG_VISIBLE_WIDTH:  cfg_q.visible_width  <= cfg_data[12:0];
				REG_VISIBLE_HEIGHT: cfg_q.visible_height <= cfg_data[12:0];
				REG_PIXEL_FORMAT:   cfg_q.pixel_format   <= cfg_data[2:0];
				REG_HEAD_MODE:      cfg_q.head_mode      <= cfg_data[1:0];
				REG_CURSOR_HOTSPOT: cfg_q.cursor_hotspot <= cfg_data[11:0];
				REG_CRTCS_SWAPPED:  cfg_q.crtcs_swapped  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// advance the held transaction when the result register is free or draining
	assign advance      = valid_s1 && (!pan_valid_q || pan_ready);
	assign cursor_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cursor_ready) begin
			valid_s1 <= cursor_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cursor_ready && cursor_valid) begin
			item_s1 <= cursor;
		end
	end

	cvp_pan_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cfg     (cfg_q),
		.item    (item_s1),
		.result  (result)
	);

	// result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_valid_q <= 1'b0;
		end else if (advance) begin
			pan_valid_q <= 1'b1;
		end else if (pan_ready) begin
			pan_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pan_q <= result;
		end
	end

	assign pan_valid = pan_valid_q;
	assign pan       = pan_q;

	`ASSERT_NXT(a_advance_fills, clk, arst_n, advance, pan_valid_q)
	`ASSERT_IMP(a_ready_only_full, clk, arst_n, !cursor_ready,
		valid_s1 && pan_valid_q && !pan_ready)
	`ASSERT_NXT(a_s1_holds, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(item_s1))

endmodule

[src/cvp_pan_core.sv]
module cvp_pan_core #(
	parameter int COORD_BITS = cvp_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  cvp_pkg::cvp_cfg_t  cfg,
	input  cvp_pkg::cvp_in_t   item,
	output cvp_pkg::cvp_out_t  result
);
	import cvp_pkg::*;

	localparam int CB = COORD_BITS;

	function automatic logic [4:0] granule(input logic [2:0] fmt, input logic [1:0] hm);
		logic [4:0] g;
		if (hm != HEAD_SINGLE) begin
			g = (fmt == FMT_RGB32) ? GRAN_DUAL_RGB32 : GRAN_DUAL;
		end else begin
			case (fmt) inside
				FMT_RGB15, FMT_RGB16: g = GRAN_RGB16;
				FMT_RGB32:            g = GRAN_RGB32;
				default:              g = GRAN_PAL8;
			endcase
		end
		return g;
	endfunction

	logic [CB-1:0]   h_start_q, v_start_q;
	logic [CB-1:0]   x_c, y_c, hds_n, vds_n, h_al, h_back, sx_raw, sx, sy;
	logic [WIDE-1:0] vw_m1, vh_m1, x_w, y_w, win_w, adj_w, h_step, v_step;
	logic [13:0]     win;
	logic [4:0]      adj;
	logic            dual_wide;

	always_comb begin
		// clamp to the virtual desktop; a zero size clamps to all ones
		vw_m1 = WIDE'(cfg.desk_width) - WIDE'(1);
		vh_m1 = WIDE'(cfg.desk_height) - WIDE'(1);
		x_c = (WIDE'(item.pos_x[CB-1:0]) >= WIDE'(cfg.desk_width)) ?
			vw_m1[CB-1:0] : item.pos_x[CB-1:0];
		y_c = (WIDE'(item.pos_y[CB-1:0]) >= WIDE'(cfg.desk_height)) ?
			vh_m1[CB-1:0] : item.pos_y[CB-1:0];
		x_w = WIDE'(x_c);
		y_w = WIDE'(y_c);

		adj   = granule(cfg.pixel_format, cfg.head_mode);
		adj_w = WIDE'(adj);
		dual_wide = (cfg.head_mode == HEAD_DUAL_ON) || (cfg.head_mode == HEAD_DUAL_SWITCH);
		win   = dual_wide ? {cfg.visible_width, 1'b0} : {1'b0, cfg.visible_width};
		win_w = WIDE'(win);

		// horizontal pan, aligned up to the granule, back one granule at the edge
		h_step = (x_w - win_w + WIDE'(1) + adj_w) & ~adj_w;
		h_al   = h_step[CB-1:0];
		h_back = h_al - (CB'(adj) + CB'(1));
		if (x_w >= win_w + WIDE'(h_start_q)) begin
			hds_n = (WIDE'(h_al) + win_w > WIDE'(cfg.desk_width)) ? h_back : h_al;
		end else if (x_c < h_start_q) begin
			hds_n = x_c & ~CB'(adj);
		end else begin
			hds_n = h_start_q;
		end

		// vertical pan
		v_step = y_w - WIDE'(cfg.visible_height) + WIDE'(1);
		if (y_w >= WIDE'(cfg.visible_height) + WIDE'(v_start_q)) begin
			vds_n = v_step[CB-1:0];
		end else if (y_c < v_start_q) begin
			vds_n = y_c;
		end else begin
			vds_n = v_start_q;
		end

		sx_raw = x_c - (hds_n + CB'(cfg.cursor_hotspot[5:0]));
		sx     = cfg.crtcs_swapped ? sx_raw - CB'(cfg.visible_width) : sx_raw;
		sy     = y_c - (vds_n + CB'(cfg.cursor_hotspot[11:6]));

		result.screen_x    = 16'(sx);
		result.screen_y    = 16'(sy);
		result.start_x     = 16'(hds_n);
		result.start_y     = 16'(vds_n);
		result.start_moved = (hds_n != h_start_q) || (vds_n != v_start_q);
	end

	// commit the panned start together with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_start_q <= '0;
			v_start_q <= '0;
		end else if (advance) begin
			h_start_q <= hds_n;
			v_start_q <= vds_n;
		end
	end

endmodule

[tb/sv/cursor_viewport_pan_top_test.sv]
module cursor_viewport_pan_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cvp_pkg::*;

	// Codes the package leaves unnamed: the catch-all format, the unused
	// format codes and the third dualhead mode.
	localparam logic [2:0]  FMT_OTHER       = 3'd4;
	localparam logic [2:0]  FMT_UNUSED_LO   = 3'd5;
	localparam logic [2:0]  FMT_UNUSED_HI   = 3'd7;
	localparam logic [1:0]  HEAD_DUAL_OTHER = 2'd3;
	localparam logic [31:0] COORD_MASK      = 32'h0000_ffff;

	localparam int N_DIR      = 46;
	localparam int N_BLOCKS   = 5;
	localparam int BLOCK_MOVES = 134;

	// One row of the directed table: either a register write or a cursor
	// move, the latter optionally with its result pinned by hand.
	typedef struct packed {
		bit         is_cfg;
		logic [2:0] idx;
		logic [13:0] val;
		logic [15:0] px;
		logic [15:0] py;
		bit         pinned;
		cvp_out_t   pan;
	} dir_row_t;

	typedef struct packed {
		bit       pinned;
		cvp_out_t pan;
	} pan_pin_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cursor_valid = 1'b0;
	logic        cursor_ready;
	cvp_in_t     cursor = '0;
	logic        pan_valid;
	logic        pan_ready = 1'b0;
	cvp_out_t    pan;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_DESK_WIDTH;
	logic [13:0] cfg_data = '0;

	// Shadow copy of the registers and of the two display start registers.
	cvp_cfg_t    shadow;
	logic [15:0] h_pan;
	logic [15:0] v_pan;

	cvp_out_t predicted_pan_q[$];
	pan_pin_t pinned_pan_q[$];

	int unsigned feed_idle = 11;
	int unsigned sink_idle = 79;
	int unsigned moves_in = 0;
	int unsigned pans_moved = 0;
	int unsigned reg_writes = 0;
	int unsigned mismatches = 0;
	logic [15:0] last_x = '0;
	logic [15:0] last_y = '0;

	// Directed moves: reset extremes first, then each granule, each head
	// mode, the right-edge step back, hotspot and swap, zero desktop and
	// zero visible window, and the largest legal sizes.
	dir_row_t dir_tab [0:N_DIR-1] = '{
		'{1'b0, '0, '0, 16'h0000, 16'h0000, 1'b1, '{16'sd0, 16'sd0, 16'd0, 16'd0, 1'b0}},
		'{1'b0, '0, '0, 16'hffff, 16'hffff, 1'b1,
			'{16'sd1023, 16'sd767, 16'd0, 16'd0, 1'b0}},
		'{1'b0, '0, '0, 16'h8000, 16'h0001, 1'b1,
			'{16'sd1023, 16'sd1, 16'd0, 16'd0, 1'b0}},
		'{1'b1, REG_DESK_WIDTH, 14'd4096, '0, '0, 1'b0, '0},
		'{1'b1, REG_DESK_HEIGHT, 14'd8192, '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd2000, 16'd0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd0, 16'd5000, 1'b0, '0},
		'{1'b0, '0, '0, 16'd0, 16'd0, 1'b0, '0},
		'{1'b1, REG_PIXEL_FORMAT, 14'(FMT_PAL8), '0, '0, 1'b0, '0},
		'{1'b1, REG_DESK_WIDTH, 14'd1030, '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd1029, 16'd0, 1'b0, '0},
		'{1'b1, REG_PIXEL_FORMAT, 14'(FMT_RGB15), '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd1029, 16'd10, 1'b0, '0},
		'{1'b1, REG_HEAD_MODE, 14'(HEAD_DUAL_ON), '0, '0, 1'b0, '0},
		'{1'b1, REG_VISIBLE_WIDTH, 14'd512, '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd1029, 16'd100, 1'b0, '0},
		'{1'b1, REG_HEAD_MODE, 14'(HEAD_DUAL_SWITCH), '0, '0, 1'b0, '0},
		'{1'b1, REG_PIXEL_FORMAT, 14'(FMT_UNUSED_HI), '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd600, 16'd300, 1'b0, '0},
		'{1'b1, REG_HEAD_MODE, 14'(HEAD_DUAL_OTHER), '0, '0, 1'b0, '0},
		'{1'b1, REG_PIXEL_FORMAT, 14'(FMT_RGB32), '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd1000, 16'd900, 1'b0, '0},
		'{1'b1, REG_PIXEL_FORMAT, 14'(FMT_OTHER), '0, '0, 1'b0, '0},
		'{1'b1, REG_HEAD_MODE, 14'(HEAD_SINGLE), '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd3, 16'd7, 1'b0, '0},
		'{1'b1, REG_PIXEL_FORMAT, 14'(FMT_RGB16), '0, '0, 1'b0, '0},
		'{1'b1, REG_PIXEL_FORMAT, 14'(FMT_UNUSED_LO), '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd517, 16'd2, 1'b0, '0},
		'{1'b1, REG_CURSOR_HOTSPOT, 14'd4095, '0, '0, 1'b0, '0},
		'{1'b1, REG_CRTCS_SWAPPED, 14'd1, '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd0, 16'd0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd1029, 16'd8191, 1'b0, '0},
		'{1'b1, REG_DESK_WIDTH, 14'd0, '0, '0, 1'b0, '0},
		'{1'b1, REG_DESK_HEIGHT, 14'd0, '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd0, 16'd0, 1'b0, '0},
		'{1'b0, '0, '0, 16'hffff, 16'hffff, 1'b0, '0},
		'{1'b1, REG_VISIBLE_WIDTH, 14'd0, '0, '0, 1'b0, '0},
		'{1'b1, REG_VISIBLE_HEIGHT, 14'd0, '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd5, 16'd5, 1'b0, '0},
		'{1'b1, REG_DESK_WIDTH, 14'd8192, '0, '0, 1'b0, '0},
		'{1'b1, REG_DESK_HEIGHT, 14'd8192, '0, '0, 1'b0, '0},
		'{1'b1, REG_VISIBLE_WIDTH, 14'd4096, '0, '0, 1'b0, '0},
		'{1'b1, REG_VISIBLE_HEIGHT, 14'd4096, '0, '0, 1'b0, '0},
		'{1'b1, REG_HEAD_MODE, 14'(HEAD_DUAL_ON), '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, 16'd8191, 16'd8191, 1'b0, '0},
		'{1'b0, '0, '0, 16'd0, 16'd0, 1'b0, '0}
	};

	cursor_viewport_pan_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cursor_valid (cursor_valid),
		.cursor_ready (cursor_ready),
		.cursor       (cursor),
		.pan_valid    (pan_valid),
		.pan_ready    (pan_ready),
		.pan          (pan),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 4 ns clock: high half, then low half.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Clamp the cursor, pan both starts to keep it visible and return the
	// on-screen position. All math runs in 32 bits and wraps to 16 only
	// where the hardware stores or reports a value.
	function automatic cvp_out_t pan_follow_cursor(input cvp_in_t pos);
		logic [31:0] x, y, hds, vds, adj, win, vis_w, vis_h, virt_w, virt_h, sx, sy;
		cvp_out_t res;
		x = 32'(pos.pos_x);
		y = 32'(pos.pos_y);
		hds = 32'(h_pan);
		vds = 32'(v_pan);
		virt_w = 32'(shadow.desk_width);
		virt_h = 32'(shadow.desk_height);
		vis_w = 32'(shadow.visible_width);
		vis_h = 32'(shadow.visible_height);
		if (shadow.head_mode != HEAD_SINGLE) begin
			adj = (shadow.pixel_format == FMT_RGB32) ? 32'(GRAN_DUAL_RGB32) : 32'(GRAN_DUAL);
		end else begin
			case (shadow.pixel_format)
				FMT_RGB15, FMT_RGB16: adj = 32'(GRAN_RGB16);
				FMT_RGB32: adj = 32'(GRAN_RGB32);
				default: adj = 32'(GRAN_PAL8);
			endcase
		end
		win = (shadow.head_mode == HEAD_DUAL_ON || shadow.head_mode == HEAD_DUAL_SWITCH)
			? vis_w << 1 : vis_w;

		// A zero-sized desktop clamps to the all-ones coordinate.
		if (x >= virt_w) x = (virt_w - 1) & COORD_MASK;
		if (y >= virt_h) y = (virt_h - 1) & COORD_MASK;

		if (x >= win + hds) begin
			hds = ((x - win) + 1 + adj) & ~adj & COORD_MASK;
			// Past the right edge: step back one granule.
			if (hds + win > virt_w) hds = (hds - (adj + 1)) & COORD_MASK;
		end else if (x < hds) begin
			hds = x & ~adj;
		end

		if (y >= vis_h + vds) vds = (y - vis_h + 1) & COORD_MASK;
		else if (y < vds) vds = y;

		res.start_moved = (hds[15:0] != h_pan) || (vds[15:0] != v_pan);
		h_pan = hds[15:0];
		v_pan = vds[15:0];

		sx = (x - (hds + 32'(shadow.cursor_hotspot[5:0]))) & COORD_MASK;
		sy = (y - (vds + 32'(shadow.cursor_hotspot[11:6]))) & COORD_MASK;
		if (shadow.crtcs_swapped) sx = (sx - vis_w) & COORD_MASK;

		res.screen_x = sx[15:0];
		res.screen_y = sy[15:0];
		res.start_x = hds[15:0];
		res.start_y = vds[15:0];
		return res;
	endfunction

	task automatic check_pan(input cvp_out_t want, input cvp_out_t got);
		if (got.screen_x !== want.screen_x) begin
			$error("screen_x: expected %0d, got %0d", want.screen_x, got.screen_x);
			mismatches++;
		end
		if (got.screen_y !== want.screen_y) begin
			$error("screen_y: expected %0d, got %0d", want.screen_y, got.screen_y);
			mismatches++;
		end
		if (got.start_x !== want.start_x) begin
			$error("start_x: expected %0d, got %0d", want.start_x, got.start_x);
			mismatches++;
		end
		if (got.start_y !== want.start_y) begin
			$error("start_y: expected %0d, got %0d", want.start_y, got.start_y);
			mismatches++;
		end
		if (got.start_moved !== want.start_moved) begin
			$error("start_moved: expected %0b, got %0b", want.start_moved, got.start_moved);
			mismatches++;
		end
	endtask

	// Register write: drive the register inputs, mirror into the shadow and
	// wait for the clock. The enable stays high across back-to-back writes
	// and is dropped by the next cursor move.
	task automatic cfg_write(input logic [2:0] idx, input logic [13:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_DESK_WIDTH: shadow.desk_width = val;
			REG_DESK_HEIGHT: shadow.desk_height = val;
			REG_VISIBLE_WIDTH: shadow.visible_width = val[12:0];
			REG_VISIBLE_HEIGHT: shadow.visible_height = val[12:0];
			REG_PIXEL_FORMAT: shadow.pixel_format = val[2:0];
			REG_HEAD_MODE: shadow.head_mode = val[1:0];
			REG_CURSOR_HOTSPOT: shadow.cursor_hotspot = val[11:0];
			REG_CRTCS_SWAPPED: shadow.crtcs_swapped = val[0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// Offer one cursor transaction and hold it until accepted. Idle cycles
	// drop valid before the offer, never after it.
	task automatic send_pos(input logic [15:0] px, input logic [15:0] py,
			input bit pinned, input cvp_out_t pin_val);
		pan_pin_t pin;
		if (cfg_we) cfg_we <= 1'b0;
		while ($urandom_range(99) < feed_idle) begin
			cursor_valid <= 1'b0;
			@(posedge clk);
		end
		cursor_valid <= 1'b1;
		cursor <= {px, py};
		pin.pinned = pinned;
		pin.pan = pin_val;
		pinned_pan_q.push_back(pin);
		last_x = px;
		last_y = py;
		do @(posedge clk); while (!cursor_ready);
	endtask

	// Drop valid and wait out every result still owed. The first edge is
	// taken unconditionally so the last acceptance is already recorded.
	task automatic settle();
		cursor_valid <= 1'b0;
		do @(posedge clk); while (predicted_pan_q.size() != 0);
	endtask

	// New display setup: mostly a desktop larger than the window so the
	// starts keep panning, with the extremes and out-of-range sizes mixed in.
	task automatic retune();
		int unsigned r, sw, sh, vw, vh, hot;
		r = $urandom_range(99);
		sw = r < 6 ? 1 : r < 12 ? 4096 : r < 14 ? 0 : r < 17 ? $urandom_range(8191, 4097)
			: $urandom_range(1024, 8);
		r = $urandom_range(99);
		sh = r < 6 ? 1 : r < 12 ? 4096 : r < 14 ? 0 : r < 17 ? $urandom_range(8191, 4097)
			: $urandom_range(1024, 8);
		r = $urandom_range(99);
		vw = r < 5 ? 1 : r < 10 ? 8192 : r < 12 ? 0 : r < 15 ? $urandom_range(16383, 8193)
			: sw * 2 + $urandom_range(512);
		if (r >= 15 && vw > 8192) vw = 8192;
		r = $urandom_range(99);
		vh = r < 5 ? 1 : r < 10 ? 8192 : r < 12 ? 0 : r < 15 ? $urandom_range(16383, 8193)
			: sh * 2 + $urandom_range(512);
		if (r >= 15 && vh > 8192) vh = 8192;
		r = $urandom_range(99);
		hot = r < 10 ? 0 : r < 20 ? 4095 : $urandom_range(4095);
		cfg_write(REG_DESK_WIDTH, vw[13:0]);
		cfg_write(REG_DESK_HEIGHT, vh[13:0]);
		cfg_write(REG_VISIBLE_WIDTH, sw[13:0]);
		cfg_write(REG_VISIBLE_HEIGHT, sh[13:0]);
		cfg_write(REG_PIXEL_FORMAT, 14'($urandom_range(7)));
		cfg_write(REG_HEAD_MODE, 14'($urandom_range(3)));
		cfg_write(REG_CURSOR_HOTSPOT, hot[13:0]);
		cfg_write(REG_CRTCS_SWAPPED, 14'($urandom_range(1)));
	endtask

	// Random cursor move: mostly a short drag from the last spot or a
	// position on or just past the desktop, sometimes anywhere in 16 bits.
	task automatic random_move();
		int unsigned r;
		int nx, ny;
		logic [15:0] px, py;
		r = $urandom_range(99);
		if (r < 45) begin
			nx = int'(last_x) + int'($urandom_range(64)) - 32;
			ny = int'(last_y) + int'($urandom_range(64)) - 32;
			px = nx[15:0];
			py = ny[15:0];
		end else if (r < 85) begin
			px = 16'($urandom_range(32'(shadow.desk_width) + 32, 0));
			py = 16'($urandom_range(32'(shadow.desk_height) + 32, 0));
		end else if (r < 95) begin
			px = 16'($urandom);
			py = 16'($urandom);
		end else begin
			px = $urandom_range(1) ? 16'hffff : 16'h0000;
			py = $urandom_range(1) ? 16'hffff : 16'h0000;
		end
		send_pos(px, py, 1'b0, '0);
	endtask

	// Result side: stall at the current sink rate.
	always @(posedge clk) begin
		pan_ready <= ($urandom_range(99) >= sink_idle);
	end

	// Scoreboard: predict on every accepted cursor transaction (a pinned
	// row overrides the prediction but the starts still advance), then
	// compare every accepted pan transaction with the oldest prediction.
	always @(posedge clk) begin
		cvp_out_t want;
		pan_pin_t pin;
		if (arst_n) begin
			if (cursor_valid && cursor_ready) begin
				want = pan_follow_cursor(cursor);
				if (want.start_moved) pans_moved++;
				pin = pinned_pan_q.pop_front();
				if (pin.pinned) want = pin.pan;
				predicted_pan_q.push_back(want);
				moves_in++;
			end
			if (pan_valid && pan_ready) begin
				if (predicted_pan_q.size() == 0) begin
					$error("pan transaction with no cursor move outstanding");
					mismatches++;
				end else begin
					check_pan(predicted_pan_q.pop_front(), pan);
				end
			end
		end
	end

	initial begin
		bit after_move;
		// Mirror the reset state of the registers and starts.
		shadow.desk_width = 14'd1024;
		shadow.desk_height = 14'd768;
		shadow.visible_width = 13'd1024;
		shadow.visible_height = 13'd768;
		shadow.pixel_format = FMT_RGB32;
		shadow.head_mode = HEAD_SINGLE;
		shadow.cursor_hotspot = '0;
		shadow.crtcs_swapped = 1'b0;
		h_pan = '0;
		v_pan = '0;
		after_move = 1'b0;

		// Hold reset, then release it once.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table. Drain before any register write that
		// follows a cursor move.
		for (int i = 0; i < N_DIR; i++) begin
			if (dir_tab[i].is_cfg) begin
				if (after_move) settle();
				after_move = 1'b0;
				cfg_write(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				send_pos(dir_tab[i].px, dir_tab[i].py, dir_tab[i].pinned, dir_tab[i].pan);
				after_move = 1'b1;
			end
		end

		// Random part in three idle profiles: busy feed with heavy stalls,
		// the reverse, then full rate. Retune the display between blocks.
		for (int ph = 0; ph < 3; ph++) begin
			feed_idle = (ph == 0) ? 11 : (ph == 1) ? 79 : 0;
			sink_idle = (ph == 0) ? 79 : (ph == 1) ? 11 : 0;
			for (int blk = 0; blk < N_BLOCKS; blk++) begin
				settle();
				retune();
				for (int n = 0; n < BLOCK_MOVES; n++) random_move();
			end
		end

		// Drain, then keep the clock running to show any stray result.
		settle();
		repeat (4) @(posedge clk);

		$display("Covered %0d cursor moves and %0d register writes; start panned on %0d moves.",
			moves_in, reg_writes, pans_moved);
		$display("Field mismatches and stray results: %0d", mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
